// ----- hdl/rekd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rekd_pkg
// Shared types and constants of the rotary encoder and key decoder.
// ----------------------------------------------------------------------------
package rekd_pkg;

    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DETENT     = 2'd2;

    localparam logic [15:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [15:0] LONG_PRESS_RESET = 16'd1000;
    localparam logic [1:0]  DETENT_RESET     = 2'b11;

    localparam logic [1:0] PHASE_CW  = 2'b10;
    localparam logic [1:0] PHASE_CCW = 2'b01;

    typedef struct packed {
        logic long_press;
        logic short_press;
        logic ccw;
        logic cw;
    } events_t;

endpackage

// ----- hdl/rekd_rotary.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rekd_rotary
// Detent decoder: holds last phase code, armed direction and detent count.
// ----------------------------------------------------------------------------
module rekd_rotary #(
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  clear,
    input  logic [1:0]            code,
    input  logic [1:0]            detent,
    output logic [COUNT_BITS-1:0] count_next,
    output rekd_pkg::events_t     ev
);

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_CW   = 2'd1,
        DIR_CCW  = 2'd2
    } dir_t;

    logic [1:0]            prev_reg;
    dir_t                  dir_reg;
    dir_t                  dir_next;
    logic [COUNT_BITS-1:0] count_reg;

    always_comb begin
        dir_next   = clear ? DIR_NONE : dir_reg;
        count_next = clear ? '0 : count_reg;
        ev         = '0;
        if (code != prev_reg) begin
            if (code == detent) begin
                if (dir_next == DIR_CW) begin
                    count_next = count_next + 1'b1;
                    ev.cw      = 1'b1;
                end else if (dir_next == DIR_CCW) begin
                    count_next = count_next - 1'b1;
                    ev.ccw     = 1'b1;
                end
                dir_next = DIR_NONE;
            end else if (prev_reg == detent) begin
                if (code == rekd_pkg::PHASE_CW) begin
                    dir_next = DIR_CW;
                end else if (code == rekd_pkg::PHASE_CCW) begin
                    dir_next = DIR_CCW;
                end else begin
                    dir_next = DIR_NONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg  <= rekd_pkg::DETENT_RESET;
            dir_reg   <= DIR_NONE;
            count_reg <= '0;
        end else if (step) begin
            prev_reg  <= code;
            dir_reg   <= dir_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hdl/rekd_key.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rekd_key
// Push key debounce and short / long press detection on millisecond stamps.
// ----------------------------------------------------------------------------
module rekd_key #(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 resync,
    input  logic                 key,
    input  logic [TIME_BITS-1:0] now,
    input  logic [15:0]          debounce_ms,
    input  logic [15:0]          long_press_ms,
    output rekd_pkg::events_t    ev
);

    logic                 seen_reg, seen_next;
    logic                 settled_reg, settled_next;
    logic                 held_reg, held_next;
    logic                 done_reg, done_next;
    logic [TIME_BITS-1:0] press_reg, press_next;
    logic [TIME_BITS-1:0] change_reg, change_next;
    logic [TIME_BITS-1:0] since_change;
    logic [TIME_BITS-1:0] since_press;

    always_comb begin
        seen_next    = seen_reg;
        settled_next = settled_reg;
        held_next    = held_reg;
        done_next    = done_reg;
        press_next   = press_reg;
        change_next  = change_reg;
        ev           = '0;
        since_change = '0;
        since_press  = '0;
        if (resync) begin
            seen_next    = key;
            settled_next = key;
            change_next  = now;
            press_next   = now;
            held_next    = 1'b0;
            done_next    = 1'b0;
        end else begin
            if (key != seen_reg) begin
                seen_next   = key;
                change_next = now;
            end
            since_change = now - change_next;
            if (since_change >= TIME_BITS'(debounce_ms) && key != settled_reg) begin
                settled_next = key;
                if (!key) begin
                    held_next  = 1'b1;
                    press_next = now;
                    done_next  = 1'b0;
                end else if (held_reg) begin
                    held_next      = 1'b0;
                    ev.short_press = !done_reg;
                end
            end
            since_press = now - press_next;
            if (held_next && !done_next && since_press >= TIME_BITS'(long_press_ms)) begin
                done_next     = 1'b1;
                ev.long_press = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= 1'b1;
            settled_reg <= 1'b1;
            held_reg    <= 1'b0;
            done_reg    <= 1'b0;
            press_reg   <= '0;
            change_reg  <= '0;
        end else if (step) begin
            seen_reg    <= seen_next;
            settled_reg <= settled_next;
            held_reg    <= held_next;
            done_reg    <= done_next;
            press_reg   <= press_next;
            change_reg  <= change_next;
        end
    end

endmodule

// ----- hdl/rotary_encoder_key_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_key_decoder
// Quadrature detent decoder with debounced push key and sticky event flags.
//
// The s_ channel carries one poll tick per word: phase levels, key level,
// millisecond stamp and the take / clear / resync commands. Every word
// gives exactly one m_ word with the detent position and the four event
// flags. Settings must be written on the cfg_ port only while no word is in
// flight; the block does not enforce this. A word sits in the input
// register, then the step logic (one 32-bit subtract and compare per key
// timer, one count increment or decrement) writes state and result register
// together; one word is accepted every cycle. When the receiver stalls, the
// result register holds, the input register fills and s_tready drops until
// the result is taken. Reset restores the register defaults, puts the
// encoder at the detent with no direction armed, zeroes the count, marks
// the key released and clears all flags; both registers come out empty.
// ----------------------------------------------------------------------------
module rotary_encoder_key_decoder #(
    parameter int unsigned TIME_BITS  = 32,
    parameter int unsigned COUNT_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // phase_a, phase_b, key_level, time_ms[31:0], take_events, clear_count,
    // resync_key, zero pad
    input  logic [rekd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // position[31:0], ev_cw, ev_ccw, ev_short, ev_long, zero pad
    output logic [rekd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [rekd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rekd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    logic [15:0]           debounce_reg;
    logic [15:0]           long_press_reg;
    logic [1:0]            detent_reg;

    logic                  in_valid_reg;
    logic [1:0]            code_reg;
    logic                  key_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic                  take_reg;
    logic                  clear_reg;
    logic                  resync_reg;

    logic                  out_valid_reg;
    logic [31:0]           position_reg;
    rekd_pkg::events_t     flags_out_reg;

    rekd_pkg::events_t     flags_reg;
    rekd_pkg::events_t     flags_next;
    rekd_pkg::events_t     rot_ev;
    rekd_pkg::events_t     key_ev;
    logic [COUNT_BITS-1:0] count_next;
    logic                  step;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, flags_out_reg.long_press, flags_out_reg.short_press,
                       flags_out_reg.ccw, flags_out_reg.cw, position_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= rekd_pkg::DEBOUNCE_RESET;
            long_press_reg <= rekd_pkg::LONG_PRESS_RESET;
            detent_reg     <= rekd_pkg::DETENT_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                rekd_pkg::REG_DEBOUNCE:   debounce_reg   <= cfg_wdata;
                rekd_pkg::REG_LONG_PRESS: long_press_reg <= cfg_wdata;
                rekd_pkg::REG_DETENT:     detent_reg     <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            code_reg   <= {s_tdata[0], s_tdata[1]};
            key_reg    <= s_tdata[2];
            now_reg    <= s_tdata[3 +: TIME_BITS];
            take_reg   <= s_tdata[35];
            clear_reg  <= s_tdata[36];
            resync_reg <= s_tdata[37];
        end
    end

    rekd_rotary #(
        .COUNT_BITS (COUNT_BITS)
    ) u_rotary (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .clear      (clear_reg),
        .code       (code_reg),
        .detent     (detent_reg),
        .count_next (count_next),
        .ev         (rot_ev)
    );

    rekd_key #(
        .TIME_BITS (TIME_BITS)
    ) u_key (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (step),
        .resync        (resync_reg),
        .key           (key_reg),
        .now           (now_reg),
        .debounce_ms   (debounce_reg),
        .long_press_ms (long_press_reg),
        .ev            (key_ev)
    );

    assign flags_next = (resync_reg ? rekd_pkg::events_t'(4'b0) : flags_reg) | rot_ev | key_ev;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (step) begin
                flags_reg <= take_reg ? rekd_pkg::events_t'(4'b0) : flags_next;
            end
            if (!out_valid_reg || m_tready) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            position_reg  <= 32'(signed'(count_next));
            flags_out_reg <= flags_next;
        end
    end

endmodule

// ----- bench/rekd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rekd_checker
// Watches both streams and the settings port of the rotary encoder and key
// decoder. Every accepted tick is run through a cycle-free model of the
// detent decoder and key debouncer; the predicted report is queued and
// compared field by field with each report taken from the m_ side.
// ----------------------------------------------------------------------------
module rekd_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    // phase_a, phase_b, key_level, time_ms[31:0], take_events, clear_count,
    // resync_key, zero pad
    input  logic [rekd_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    // position[31:0], ev_cw, ev_ccw, ev_short, ev_long, zero pad
    input  logic [rekd_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [rekd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rekd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                  mismatches,
    output int                                  pending
);

    typedef struct packed {
        logic [1:0]  pad;
        logic        resync_key;
        logic        clear_count;
        logic        take_events;
        logic [31:0] time_ms;
        logic        key_level;
        logic        phase_b;
        logic        phase_a;
    } tick_t;

    typedef struct packed {
        logic [3:0]           pad;
        rekd_pkg::events_t    flags;
        logic signed [31:0]   position;
    } report_t;

    typedef enum logic [1:0] {
        ARM_NONE = 2'd0,
        ARM_CW   = 2'd1,
        ARM_CCW  = 2'd2
    } arm_t;

    logic [15:0]        debounce_q;
    logic [15:0]        long_press_q;
    logic [1:0]         detent_q;

    logic [1:0]         last_code;
    arm_t               armed;
    logic [31:0]        detents;
    rekd_pkg::events_t  sticky;
    logic               key_seen;
    logic               key_settled;
    logic               key_held;
    logic               long_sent;
    logic [31:0]        press_stamp;
    logic [31:0]        change_stamp;

    report_t            expected_reports[$];
    int                 fault_count = 0;

    function automatic report_t poll_tick(tick_t tk);
        logic [1:0] code;
        logic [1:0] prior;
        report_t    rep;
        code = {tk.phase_a, tk.phase_b};
        if (tk.clear_count) begin
            detents = '0;
            armed = ARM_NONE;
        end
        if (tk.resync_key) begin
            key_seen = tk.key_level;
            key_settled = tk.key_level;
            change_stamp = tk.time_ms;
            press_stamp = tk.time_ms;
            key_held = 1'b0;
            long_sent = 1'b0;
            sticky = '0;
        end

        prior = last_code;
        last_code = code;
        if (code != prior) begin
            if (code == detent_q) begin
                if (armed == ARM_CW) begin
                    detents = detents + 32'd1;
                    sticky.cw = 1'b1;
                end else if (armed == ARM_CCW) begin
                    detents = detents - 32'd1;
                    sticky.ccw = 1'b1;
                end
                armed = ARM_NONE;
            end else if (prior == detent_q) begin
                if (code == rekd_pkg::PHASE_CW) begin
                    armed = ARM_CW;
                end else if (code == rekd_pkg::PHASE_CCW) begin
                    armed = ARM_CCW;
                end else begin
                    armed = ARM_NONE;
                end
            end
        end

        if (!tk.resync_key) begin
            if (tk.key_level != key_seen) begin
                key_seen = tk.key_level;
                change_stamp = tk.time_ms;
            end
            if ((tk.time_ms - change_stamp) >= {16'd0, debounce_q}
                    && tk.key_level != key_settled) begin
                key_settled = tk.key_level;
                if (!tk.key_level) begin
                    key_held = 1'b1;
                    press_stamp = tk.time_ms;
                    long_sent = 1'b0;
                end else if (key_held) begin
                    key_held = 1'b0;
                    if (!long_sent) begin
                        sticky.short_press = 1'b1;
                    end
                end
            end
            if (key_held && !long_sent
                    && (tk.time_ms - press_stamp) >= {16'd0, long_press_q}) begin
                long_sent = 1'b1;
                sticky.long_press = 1'b1;
            end
        end

        rep = '0;
        rep.position = detents;
        rep.flags = sticky;
        if (tk.take_events) begin
            sticky = '0;
        end
        return rep;
    endfunction

    always @(posedge aclk) begin
        report_t got;
        report_t want;
        if (!aresetn) begin
            debounce_q   = rekd_pkg::DEBOUNCE_RESET;
            long_press_q = rekd_pkg::LONG_PRESS_RESET;
            detent_q     = rekd_pkg::DETENT_RESET;
            last_code    = rekd_pkg::DETENT_RESET;
            armed        = ARM_NONE;
            detents      = '0;
            sticky       = '0;
            key_seen     = 1'b1;
            key_settled  = 1'b1;
            key_held     = 1'b0;
            long_sent    = 1'b0;
            press_stamp  = '0;
            change_stamp = '0;
            expected_reports.delete();
            pending <= 0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    rekd_pkg::REG_DEBOUNCE:   debounce_q   = cfg_wdata;
                    rekd_pkg::REG_LONG_PRESS: long_press_q = cfg_wdata;
                    rekd_pkg::REG_DETENT:     detent_q     = cfg_wdata[1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_reports.size() == 0) begin
                    if (fault_count < 10) begin
                        $display("[%0t] unexpected word: pos=%0d flags=%b",
                                 $realtime, got.position, got.flags);
                    end
                    fault_count++;
                end else begin
                    want = expected_reports.pop_front();
                    if (got.position !== want.position || got.flags !== want.flags) begin
                        if (fault_count < 10) begin
                            $display(
                                "[%0t] mismatch: expected pos=%0d flags=%b, got pos=%0d flags=%b",
                                $realtime, want.position, want.flags,
                                got.position, got.flags);
                        end
                        fault_count++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_reports.push_back(poll_tick(s_tdata));
            end
            pending <= expected_reports.size();
        end
        mismatches <= fault_count;
    end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the rotary encoder and key decoder. A directed
// opening turns the knob both ways and presses the key short and long, then
// randomized phases walk the Gray sequence and toggle the key under a set of
// settings that includes the extremes. Both sides idle in random bursts, and
// one phase holds the receiver off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;

    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_TICKS    = 150;
    localparam int PHASES         = 10;

    logic                               aclk      = 1'b0;
    logic                               aresetn   = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [rekd_pkg::IN_TDATA_W-1:0]    s_tdata   = '0;
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [rekd_pkg::OUT_TDATA_W-1:0]   m_tdata;
    logic                               cfg_we    = 1'b0;
    logic [rekd_pkg::CFG_INDEX_W-1:0]   cfg_index = rekd_pkg::REG_DEBOUNCE;
    logic [rekd_pkg::CFG_DATA_W-1:0]    cfg_wdata = '0;

    int          mismatches;
    int          pending;
    bit          tx_idle       = 1'b0;
    bit          rx_idle       = 1'b0;
    int          hold_requests = 0;
    int          holds_served  = 0;
    int          stall_left    = 0;
    int          quiet_cycles  = 0;
    logic [31:0] now_ms        = '0;
    logic [15:0] debounce_set  = rekd_pkg::DEBOUNCE_RESET;
    logic [15:0] long_set      = rekd_pkg::LONG_PRESS_RESET;
    logic [1:0]  gray_pos      = 2'd2;
    logic [1:0]  spin          = 2'd1;
    bit          key_up        = 1'b1;

    always #6 aclk = ~aclk;

    rotary_encoder_key_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rekd_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            stall_left <= LONG_HOLD;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (rx_idle && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 18);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_tick(input logic a, input logic b, input logic key,
                             input logic [31:0] stamp, input logic take,
                             input logic clr, input logic resync);
        if (tx_idle && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, resync, clr, take, stamp, key, b, a};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [15:0] deb, input logic [15:0] hold,
                                  input logic [1:0] det);
        debounce_set = deb;
        long_set = hold;
        cfg_we    <= 1'b1;
        cfg_index <= rekd_pkg::REG_DEBOUNCE;
        cfg_wdata <= deb;
        @(posedge aclk);
        cfg_index <= rekd_pkg::REG_LONG_PRESS;
        cfg_wdata <= hold;
        @(posedge aclk);
        cfg_index <= rekd_pkg::REG_DETENT;
        cfg_wdata <= {14'd0, det};
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // walk the Gray cycle with a sticky direction, flip the key now and then
    task automatic spin_and_press(input int count);
        int          roll;
        logic [1:0]  code;
        logic        key;
        logic [31:0] span;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 8) begin
                spin = -spin;
            end
            roll = $urandom_range(0, 9);
            if (roll < 6) begin
                gray_pos = gray_pos + spin;
            end else if (roll == 9) begin
                gray_pos = 2'($urandom_range(0, 3));
            end
            code = gray_pos ^ (gray_pos >> 1);

            if ($urandom_range(0, 9) == 0) begin
                key_up = ~key_up;
            end
            key = key_up;
            if ($urandom_range(0, 19) == 0) begin
                key = ~key;
            end

            span = {16'd0, (long_set > debounce_set) ? long_set : debounce_set};
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
                now_ms = $urandom();
            end else if (roll < 70) begin
                now_ms = now_ms + $urandom_range(0, debounce_set / 4 + 3);
            end else begin
                now_ms = now_ms + $urandom_range(0, span / 2 + 3);
            end

            send_tick(code[1], code[0], key, now_ms, $urandom_range(0, 2) == 0,
                      $urandom_range(0, 29) == 0, $urandom_range(0, 29) == 0);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        tx_idle = 1'b1;
        rx_idle <= 1'b1;

        send_tick(1'b1, 1'b1, 1'b1, 32'd0,    1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1, 32'd10,   1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 32'd20,   1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1, 32'd30,   1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 32'd40,   1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1, 32'd50,   1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 32'd60,   1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b0, 1'b1, 32'd70,   1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 32'd80,   1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b1, 32'd85,   1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 32'd88,   1'b0, 1'b0, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1, 32'd90,   1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 32'd100,  1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0, 32'd110,  1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0, 32'd125,  1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0, 32'd130,  1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 32'd140,  1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 32'd160,  1'b1, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0, 32'd200,  1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0, 32'd220,  1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0, 32'd1220, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 32'd1300, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 32'd1320, 1'b1, 1'b0, 1'b0);
        send_tick(1'b0, 1'b1, 1'b0, 32'hFFFF_FFF0, 1'b0, 1'b1, 1'b0);
        send_tick(1'b1, 1'b1, 1'b0, 32'h0000_0004, 1'b0, 1'b0, 1'b0);
        send_tick(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
        send_tick(1'b1, 1'b0, 1'b1, 32'd0,    1'b0, 1'b0, 1'b1);
        s_tvalid <= 1'b0;
        drain();

        for (int p = 0; p < PHASES; p++) begin
            unique case (p)
                0: write_settings(16'd0, 16'd0, 2'd0);
                1: write_settings(16'hFFFF, 16'hFFFF, 2'd3);
                2: write_settings(16'd20, 16'd1000, 2'd1);
                3: write_settings(16'd5, 16'd40, 2'd2);
                4: write_settings(16'd0, 16'hFFFF, 2'd3);
                5: write_settings(16'hFFFF, 16'd0, 2'd0);
                6: write_settings(16'($urandom_range(0, 65535)),
                                  16'($urandom_range(0, 65535)),
                                  2'($urandom_range(0, 3)));
                7: write_settings(16'($urandom_range(0, 60)), 16'($urandom_range(0, 600)),
                                  2'($urandom_range(0, 3)));
                8: write_settings(rekd_pkg::DEBOUNCE_RESET, rekd_pkg::LONG_PRESS_RESET,
                                  rekd_pkg::DETENT_RESET);
                default: write_settings(16'($urandom_range(0, 40)),
                                        16'($urandom_range(0, 400)),
                                        2'($urandom_range(0, 3)));
            endcase
            tx_idle = (p < PHASES - 1) && (p != 8) && ($urandom_range(0, 3) != 0);
            rx_idle <= (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
            now_ms = $urandom();
            if (p == 8) begin
                spin_and_press(40);
                hold_requests <= hold_requests + 1;
                spin_and_press(PHASE_TICKS - 40);
            end else begin
                spin_and_press(PHASE_TICKS);
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (mismatches == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rekd_pkg.sv
hdl/rekd_rotary.sv
hdl/rekd_key.sv
hdl/rotary_encoder_key_decoder.sv
bench/rekd_checker.sv
bench/tb.sv
